// ===== hdl/lpec_pkg.sv =====
package lpec_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_CHECK_MODE       = 1'b0;
  localparam logic CFG_EXPECTED_PATTERN = 1'b1;

  // Check modes
  localparam logic MODE_PRBS7    = 1'b0;
  localparam logic MODE_CONSTANT = 1'b1;

  localparam int unsigned WORD_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH = 6;
  localparam int unsigned SHOW_WIDTH  = 16;
  localparam int unsigned HIST_WIDTH  = 7;

  // Bits of the first word of a capture that are judged (all but the first seven)
  localparam logic [WORD_WIDTH-1:0] FIRST_WORD_MASK = 32'h01FF_FFFF;

  // Per-word counts handed from the bit check stage to the totals stage
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] errs;
    logic                   mism;
    logic [COUNT_WIDTH-1:0] rise;
    logic [COUNT_WIDTH-1:0] fall;
    logic                   all_zero;
    logic                   last;
  } counts_t;

  // Population count of a word as a balanced adder tree
  function automatic logic [COUNT_WIDTH-1:0] popcount32(input logic [WORD_WIDTH-1:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

// ===== hdl/link_pattern_error_checker_core.sv =====
// Link pattern error checker: judges 32-bit words captured from a serial link, earliest
// bit in the MSB. In PRBS7 mode (check_mode = 0) each bit must equal the XOR of the bits
// six and seven places earlier; the first seven bits of a capture only seed the history.
// In constant mode (check_mode = 1) each word is compared with expected_pattern and the
// 0-to-1 (rise) and 1-to-0 (fall) flips are counted. Running totals saturate at
// 2^TOTAL_WIDTH - 1 and show their low 16 bits. A word with capture_end set closes the
// capture: its result carries the totals including that word, then all state clears.
// One word is taken per clock while the output is not stalled; a word passes through
// the input register, which loads at acceptance, then the per-word count register,
// then the totals/result register, and a stalled output back-pressures
// through the pipeline. Write configuration only while idle.
module link_pattern_error_checker_core #(
  parameter int unsigned TOTAL_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_index,
  input  logic [lpec_pkg::WORD_WIDTH-1:0]      cfg_data,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lpec_pkg::WORD_WIDTH-1:0]      link_word,
  input  logic                                 capture_end,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lpec_pkg::COUNT_WIDTH-1:0]     word_bit_errors,
  output logic                                 word_mismatch,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      bit_error_total,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      mismatch_total,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      rise_error_total,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      fall_error_total,
  output logic                                 all_zero_seen,
  output logic                                 capture_done
);

  logic                               check_mode;
  logic [lpec_pkg::WORD_WIDTH-1:0]    expected_pattern;

  // input register stage
  logic                               in_hold_valid;
  logic [lpec_pkg::WORD_WIDTH-1:0]    in_hold_word;
  logic                               in_hold_last;

  // count register stage
  logic                               cnt_valid;
  lpec_pkg::counts_t                  counts;

  logic                               in_fire;
  logic                               res_free;
  logic                               cnt_free;
  logic                               load_cnt;
  logic                               load_res;

  // Configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode       <= lpec_pkg::MODE_PRBS7;
      expected_pattern <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lpec_pkg::CFG_CHECK_MODE:       check_mode       <= cfg_data[0];
        lpec_pkg::CFG_EXPECTED_PATTERN: expected_pattern <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance each stage when the one after it is empty or emptying this cycle
  assign res_free = ~out_valid | out_ready;
  assign load_res = cnt_valid & res_free;
  assign cnt_free = ~cnt_valid | res_free;
  assign load_cnt = in_hold_valid & cnt_free;
  assign in_ready = ~in_hold_valid | cnt_free;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold_valid <= 1'b0;
      cnt_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        in_hold_valid <= 1'b1;
      end else if (load_cnt) begin
        in_hold_valid <= 1'b0;
      end
      if (load_cnt) begin
        cnt_valid <= 1'b1;
      end else if (load_res) begin
        cnt_valid <= 1'b0;
      end
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted word until the count stage takes it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_hold_word <= link_word;
      in_hold_last <= capture_end;
    end
  end

  lpec_bit_check u_bit_check (
    .clk              (clk),
    .rst              (rst),
    .load             (load_cnt),
    .check_mode       (check_mode),
    .expected_pattern (expected_pattern),
    .link_word        (in_hold_word),
    .capture_end      (in_hold_last),
    .counts           (counts)
  );

  lpec_totals #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_totals (
    .clk              (clk),
    .rst              (rst),
    .load             (load_res),
    .counts           (counts),
    .word_bit_errors  (word_bit_errors),
    .word_mismatch    (word_mismatch),
    .bit_error_total  (bit_error_total),
    .mismatch_total   (mismatch_total),
    .rise_error_total (rise_error_total),
    .fall_error_total (fall_error_total),
    .all_zero_seen    (all_zero_seen),
    .capture_done     (capture_done)
  );

  a_mismatch_has_errors: assert property (@(posedge clk) disable iff (rst)
    (out_valid && word_mismatch) |-> (word_bit_errors != '0))
    else $error("mismatching word reported with no bit errors");

  a_errors_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_bit_errors <= lpec_pkg::COUNT_WIDTH'(lpec_pkg::WORD_WIDTH)))
    else $error("per-word error count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_res)
    else $error("result register overwritten while stalled");

endmodule

// ===== hdl/lpec_bit_check.sv =====
module lpec_bit_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic                                 check_mode,
  input  logic [lpec_pkg::WORD_WIDTH-1:0]      expected_pattern,
  input  logic [lpec_pkg::WORD_WIDTH-1:0]      link_word,
  input  logic                                 capture_end,
  output lpec_pkg::counts_t                    counts
);

  logic [lpec_pkg::HIST_WIDTH-1:0] history;
  logic                            primed;
  logic                            one_seen;

  logic [lpec_pkg::WORD_WIDTH+lpec_pkg::HIST_WIDTH-1:0] stream;
  logic [lpec_pkg::WORD_WIDTH-1:0] prbs_err;
  logic [lpec_pkg::WORD_WIDTH-1:0] diff;
  logic [lpec_pkg::WORD_WIDTH-1:0] err_vec;
  logic                            is_const;
  logic                            word_nz;
  lpec_pkg::counts_t               counts_next;

  // Oldest history bit sits at the top, the word's earliest bit just below the history
  assign stream = {history, link_word};

  always_comb begin
    for (int i = 0; i < lpec_pkg::WORD_WIDTH; i++) begin
      prbs_err[i] = stream[i] ^ stream[i+6] ^ stream[i+7];
    end
  end

  assign is_const = (check_mode == lpec_pkg::MODE_CONSTANT);
  assign diff     = link_word ^ expected_pattern;
  assign err_vec  = is_const ? diff
                  : (primed ? prbs_err : (prbs_err & lpec_pkg::FIRST_WORD_MASK));
  assign word_nz  = |link_word;

  always_comb begin
    counts_next.errs     = lpec_pkg::popcount32(err_vec);
    counts_next.mism     = is_const & (|diff);
    counts_next.rise     = is_const ? lpec_pkg::popcount32(link_word & ~expected_pattern)
                                    : '0;
    counts_next.fall     = is_const ? lpec_pkg::popcount32(~link_word & expected_pattern)
                                    : '0;
    counts_next.all_zero = ~(one_seen | word_nz);
    counts_next.last     = capture_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history  <= '0;
      primed   <= 1'b0;
      one_seen <= 1'b0;
    end else if (load) begin
      if (capture_end) begin
        history  <= '0;
        primed   <= 1'b0;
        one_seen <= 1'b0;
      end else begin
        history  <= link_word[lpec_pkg::HIST_WIDTH-1:0];
        primed   <= 1'b1;
        one_seen <= one_seen | word_nz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      counts <= counts_next;
    end
  end

endmodule

// ===== hdl/lpec_totals.sv =====
module lpec_totals #(
  parameter int unsigned TOTAL_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  lpec_pkg::counts_t                    counts,
  output logic [lpec_pkg::COUNT_WIDTH-1:0]     word_bit_errors,
  output logic                                 word_mismatch,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      bit_error_total,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      mismatch_total,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      rise_error_total,
  output logic [lpec_pkg::SHOW_WIDTH-1:0]      fall_error_total,
  output logic                                 all_zero_seen,
  output logic                                 capture_done
);

  logic [TOTAL_WIDTH-1:0] err_sum;
  logic [TOTAL_WIDTH-1:0] mism_sum;
  logic [TOTAL_WIDTH-1:0] rise_sum;
  logic [TOTAL_WIDTH-1:0] fall_sum;
  logic [TOTAL_WIDTH-1:0] err_sum_next;
  logic [TOTAL_WIDTH-1:0] mism_sum_next;
  logic [TOTAL_WIDTH-1:0] rise_sum_next;
  logic [TOTAL_WIDTH-1:0] fall_sum_next;

  function automatic logic [TOTAL_WIDTH-1:0] sat_add(input logic [TOTAL_WIDTH-1:0] s,
                                                     input logic [lpec_pkg::COUNT_WIDTH-1:0] n);
    logic [TOTAL_WIDTH:0] w;
    w = {1'b0, s} + (TOTAL_WIDTH+1)'(n);
    return w[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : w[TOTAL_WIDTH-1:0];
  endfunction

  function automatic logic [lpec_pkg::SHOW_WIDTH-1:0] show(input logic [TOTAL_WIDTH-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[lpec_pkg::SHOW_WIDTH-1:0];
  endfunction

  assign err_sum_next  = sat_add(err_sum, counts.errs);
  assign mism_sum_next = sat_add(mism_sum, lpec_pkg::COUNT_WIDTH'(counts.mism));
  assign rise_sum_next = sat_add(rise_sum, counts.rise);
  assign fall_sum_next = sat_add(fall_sum, counts.fall);

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sum  <= '0;
      mism_sum <= '0;
      rise_sum <= '0;
      fall_sum <= '0;
    end else if (load) begin
      if (counts.last) begin
        err_sum  <= '0;
        mism_sum <= '0;
        rise_sum <= '0;
        fall_sum <= '0;
      end else begin
        err_sum  <= err_sum_next;
        mism_sum <= mism_sum_next;
        rise_sum <= rise_sum_next;
        fall_sum <= fall_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_bit_errors  <= counts.errs;
      word_mismatch    <= counts.mism;
      bit_error_total  <= show(err_sum_next);
      mismatch_total   <= show(mism_sum_next);
      rise_error_total <= show(rise_sum_next);
      fall_error_total <= show(fall_sum_next);
      all_zero_seen    <= counts.all_zero;
      capture_done     <= counts.last;
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (load && counts.last) |=>
      (err_sum == '0 && mism_sum == '0 && rise_sum == '0 && fall_sum == '0))
    else $error("totals not cleared after final word");

  a_errors_counted: assert property (@(posedge clk) disable iff (rst)
    (load && !counts.last && counts.errs != '0) |=> (err_sum != '0))
    else $error("bit errors lost from running total");

  a_mismatch_counted: assert property (@(posedge clk) disable iff (rst)
    (load && !counts.last && counts.mism) |=> (mism_sum != '0))
    else $error("mismatching word lost from running total");

endmodule
